// File: hw/rtl/rhfc_pkg.sv
// Shared types, constants and the byte-wise CRC-32 step for the record header framer.
// Used by every module of the block; no dependencies.
package rhfc_pkg;

   // Header layout
   localparam int HEADER_BYTES = 40;
   localparam int CRC_SPAN     = 36;
   localparam int BODY_W       = CRC_SPAN * 8;
   localparam int COUNT_W      = $clog2(HEADER_BYTES);

   localparam logic [31:0] HDR_MAGIC       = 32'h454F_5332;
   localparam logic [15:0] VERSION_DEFAULT = 16'd2;

   // Reflected CRC-32
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [15:0] record_type;
      logic [31:0] record_flags;
      logic [63:0] sequence_number;
      logic [63:0] capture_time_us;
      logic [31:0] payload_bytes;
      logic [31:0] payload_crc;
   } req_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       last_byte;
   } rsp_type;

   // First 36 header bytes, byte 0 in the top bits
   typedef logic [BODY_W-1:0] body_type;

   // Fold one byte into the running CRC, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/rhfc_front.sv
// Front stage: holds the version register, accepts request items and packs header bodies.
// Depends on rhfc_pkg.
module rhfc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  rhfc_pkg::req_type  req_data,
   output logic               push,
   output rhfc_pkg::body_type push_data,
   input  logic               q_full
);

   logic [15:0]        ver_ff, ver_in;
   logic               front_valid_ff, front_valid_in;
   rhfc_pkg::body_type body_ff, body_in;
   logic               accept;

   // Hand the packed body to the queue when it has room
   assign push      = front_valid_ff && !q_full;
   assign push_data = body_ff;
   assign req_stall = front_valid_ff && !push;
   assign accept    = req_valid && !req_stall;

   // Update version on a write
   always_comb begin
      ver_in = csr_wr_en ? csr_wr_data : ver_ff;
   end

   // Capture and pack an item
   always_comb begin
      front_valid_in = front_valid_ff;
      body_in        = body_ff;
      if (push) begin
         front_valid_in = 1'b0;
      end
      if (accept) begin
         front_valid_in = 1'b1;
         body_in = {rhfc_pkg::HDR_MAGIC, ver_ff, req_data.record_type,
                    req_data.record_flags, req_data.sequence_number,
                    req_data.capture_time_us, req_data.payload_bytes,
                    req_data.payload_crc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff         <= rhfc_pkg::VERSION_DEFAULT;
         front_valid_ff <= 1'b0;
      end else begin
         ver_ff         <= ver_in;
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

endmodule

// File: hw/rtl/rhfc_queue.sv
// Short queue of packed header bodies between the front and back stages.
// Depends on rhfc_pkg.
module rhfc_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rhfc_pkg::body_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               q_valid,
   output rhfc_pkg::body_type q_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rhfc_pkg::body_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/rhfc_back.sv
// Back stage: serializes one header body a byte per cycle when not stalled, folds the CRC and appends it.
// Depends on rhfc_pkg.
module rhfc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  rhfc_pkg::body_type q_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rhfc_pkg::rsp_type  rsp_data
);

   localparam int CW = rhfc_pkg::COUNT_W;

   logic               active_ff, active_in;
   logic [CW-1:0]      count_ff, count_in;
   rhfc_pkg::body_type shift_ff, shift_in;
   logic [31:0]        crc_ff, crc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rhfc_pkg::rsp_type  rsp_ff, rsp_in;
   logic               advance, finishing, in_body;
   logic [7:0]         body_byte, crc_out_byte;
   logic [31:0]        crc_fin;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign finishing = active_ff && (count_ff == CW'(rhfc_pkg::HEADER_BYTES - 1));
   assign in_body   = (count_ff < CW'(rhfc_pkg::CRC_SPAN));
   assign pop       = advance && q_valid && (!active_ff || finishing);
   assign body_byte = shift_ff[rhfc_pkg::BODY_W-1 -: 8];
   assign crc_fin   = crc_ff ^ rhfc_pkg::CRC_ONES;

   // Select the CRC byte, most significant first
   always_comb begin
      case (count_ff[1:0])
         2'd0:    crc_out_byte = crc_fin[31:24];
         2'd1:    crc_out_byte = crc_fin[23:16];
         2'd2:    crc_out_byte = crc_fin[15:8];
         2'd3:    crc_out_byte = crc_fin[7:0];
         default: crc_out_byte = crc_fin[7:0];
      endcase
   end

   // Emit one byte per advance, load the next body as the last byte leaves
   always_comb begin
      active_in    = active_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = active_ff;
         rsp_in.header_byte = in_body ? body_byte : crc_out_byte;
         rsp_in.last_byte   = finishing;
         if (active_ff) begin
            count_in = count_ff + 1'b1;
            if (in_body) begin
               shift_in = shift_ff << 8;
               crc_in   = rhfc_pkg::crc_byte(crc_ff, body_byte);
            end
            if (finishing) begin
               active_in = 1'b0;
            end
         end
         if (pop) begin
            active_in = 1'b1;
            count_in  = '0;
            shift_in  = q_data;
            crc_in    = rhfc_pkg::CRC_ONES;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      crc_ff   <= crc_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/record_header_framer_crc32.sv
// Record header framer: one request item in, forty header bytes out, CRC-32 on the tail.
// Items pass the front register and the queue to rhfc_back, which emits one registered
// byte a cycle while rsp_stall is low and loads the next body as the last byte leaves.
// Front stage plus QUEUE_DEPTH queued bodies let new items enter while a header drains.
// Synchronous active-high reset clears control state; the version register resets to 2.
module record_header_framer_crc32 #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  rhfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rhfc_pkg::rsp_type rsp_data
);

   logic               push, q_full, pop, q_valid;
   rhfc_pkg::body_type push_data, q_data;

   rhfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .push        (push),
      .push_data   (push_data),
      .q_full      (q_full)
   );

   rhfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   rhfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
